// ===== rtl/vsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsp_pkg: shared types and constants of the version string parser
// character codes, phase codes, parser state and result records
// ----------------------------------------------------------------------------
package vsp_pkg;

   // upper bound of one numeric part, clipped to the 16-bit result fields
   localparam int unsigned PART_MAX   = 32'd65535;
   localparam logic [15:0] PART_LIMIT =
      16'((PART_MAX < 32'd65535) ? PART_MAX : 32'd65535);

   // character codes
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_DASH = 8'h2d;
   localparam logic [7:0] CH_DOT  = 8'h2e;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_V = 8'h56;
   localparam logic [7:0] CH_UP_Z = 8'h5a;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_V = 8'h76;
   localparam logic [7:0] CH_LO_Z = 8'h7a;

   // parser phases
   localparam logic [2:0] PH_START     = 3'd0;
   localparam logic [2:0] PH_MAJOR     = 3'd1;
   localparam logic [2:0] PH_MINOR     = 3'd2;
   localparam logic [2:0] PH_PATCH     = 3'd3;
   localparam logic [2:0] PH_SUF_EMPTY = 3'd4;
   localparam logic [2:0] PH_SUF       = 3'd5;

   typedef struct packed {
      logic [2:0]  phase;
      logic        failed;
      logic        digit_seen;
      logic [15:0] accum;
      logic [15:0] major_hold;
      logic [15:0] minor_hold;
   } parse_state_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] ver_major;
      logic [15:0] ver_minor;
      logic [15:0] ver_patch;
      logic        suffix_flag;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase: PH_START, failed: 1'b0, digit_seen: 1'b0,
      accum: 16'd0, major_hold: 16'd0, minor_hold: 16'd0};

   function automatic logic is_dec_digit(input logic [7:0] c);
      return c inside {[CH_0:CH_9]};
   endfunction

   function automatic logic is_suffix_char(input logic [7:0] c);
      return c inside {[CH_0:CH_9], [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z],
                       CH_DOT, CH_DASH};
   endfunction

endpackage

// ===== rtl/version_string_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_parser: streaming parser for dotted version strings
// reads [v|V]major.minor.patch[-suffix] one byte per item, zero terminated
// ----------------------------------------------------------------------------
// usage
//  - req channel: one byte of the string per item on req_ch; a zero byte
//    ends the string and produces exactly one result item
//  - rsp channel: valid flag, the three parts and the suffix flag; when the
//    string is invalid every field is zero
//  - throughput: one byte per cycle unless req_stall holds the input, also across string boundaries
//  - a terminator passes the input register, then the result register written
//    from the step; it waits in the input register while the result slot is full
//  - the parser state is updated by one step of shift-add and compare logic
//    per byte, which sets the single-cycle rate
//  - when the receiver stalls, the result register holds; nonzero bytes keep
//    flowing, and only a second terminator waits in the input register
//  - reset clears the input and result valids and returns the parser to
//    the start of a string
// ----------------------------------------------------------------------------
module version_string_parser
   import vsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [15:0] rsp_ver_major,
   output logic [15:0] rsp_ver_minor,
   output logic [15:0] rsp_ver_patch,
   output logic        rsp_suffix_flag
);

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_ch_ff;

   // parser state
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      step_res;

   // result register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   result_type      rsp_ff;

   logic            out_free;
   logic            proc;
   logic            is_term;

   assign is_term  = (in_ch_ff == CH_NUL);
   // the result slot is free if empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // a byte moves on unless it is a terminator with nowhere to go
   assign proc     = in_valid_ff && (!is_term || out_free);
   assign req_stall = in_valid_ff && !proc;

   vsp_step u_step (
      .cur_state (state_ff),
      .ch        (in_ch_ff),
      .nxt_state (state_in),
      .result    (step_res)
   );

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = (proc && is_term) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ch_ff <= req_ch;
      end
      if (proc && is_term) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = rsp_ff.valid_res;
   assign rsp_ver_major   = rsp_ff.ver_major;
   assign rsp_ver_minor   = rsp_ff.ver_minor;
   assign rsp_ver_patch   = rsp_ff.ver_patch;
   assign rsp_suffix_flag = rsp_ff.suffix_flag;

`ifndef NO_ASSERTIONS
   // an invalid result carries all-zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.valid_res |->
         rsp_ff.ver_major == 16'd0 && rsp_ff.ver_minor == 16'd0 &&
         rsp_ff.ver_patch == 16'd0 && !rsp_ff.suffix_flag)
      else $error("invalid result with nonzero fields");

   // a suffix is only reported on a valid string
   a_suffix_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.suffix_flag |-> rsp_ff.valid_res)
      else $error("suffix flag on invalid result");

   // a terminator returns the parser to the start of a string
   a_term_restart: assert property (@(posedge clock) disable iff (reset)
      proc && is_term |=> state_ff.phase == PH_START && !state_ff.failed &&
         state_ff.accum == 16'd0)
      else $error("parser not restarted after terminator");

   // a result only appears after a terminator was processed
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && is_term))
      else $error("result without terminator");
`endif

endmodule

// ===== rtl/vsp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsp_step: next-state and result logic for one byte
// advances the parser by one character; a zero byte closes the string
// ----------------------------------------------------------------------------
module vsp_step
   import vsp_pkg::*;
(
   input  parse_state_type cur_state,
   input  logic [7:0]      ch,
   output parse_state_type nxt_state,
   output result_type      result
);

   logic [2:0]  pe;
   logic [15:0] acc;
   logic        ds;
   logic [19:0] prod;
   logic [15:0] acc_sat;
   logic        ok;

   // a new string enters the major part with a cleared accumulator
   assign pe   = (cur_state.phase == PH_START) ? PH_MAJOR : cur_state.phase;
   assign acc  = (cur_state.phase == PH_START) ? 16'd0 : cur_state.accum;
   assign ds   = (cur_state.phase == PH_START) ? 1'b0 : cur_state.digit_seen;

   // acc * 10 + digit as shift and add
   assign prod = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(ch[3:0]);
   assign acc_sat = (prod > 20'(PART_LIMIT)) ? PART_LIMIT : prod[15:0];

   assign ok = !cur_state.failed &&
               ((cur_state.phase == PH_PATCH && cur_state.digit_seen) ||
                cur_state.phase == PH_SUF);

   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      if (ch == CH_NUL) begin
         if (ok) begin
            result.valid_res   = 1'b1;
            result.ver_major   = cur_state.major_hold;
            result.ver_minor   = cur_state.minor_hold;
            result.ver_patch   = cur_state.accum;
            result.suffix_flag = (cur_state.phase == PH_SUF);
         end
         nxt_state = STATE_RESET;
      end else if (!cur_state.failed) begin
         nxt_state.phase      = pe;
         nxt_state.accum      = acc;
         nxt_state.digit_seen = ds;
         if (cur_state.phase == PH_START && (ch == CH_LO_V || ch == CH_UP_V)) begin
            // optional prefix, nothing else to do
         end else begin
            case (pe)
               PH_MAJOR, PH_MINOR, PH_PATCH: begin
                  if (is_dec_digit(ch)) begin
                     nxt_state.accum      = acc_sat;
                     nxt_state.digit_seen = 1'b1;
                  end else if (ch == CH_DOT && pe != PH_PATCH && ds) begin
                     if (pe == PH_MAJOR) begin
                        nxt_state.major_hold = acc;
                     end else begin
                        nxt_state.minor_hold = acc;
                     end
                     nxt_state.phase      = 3'(pe + 3'd1);
                     nxt_state.accum      = 16'd0;
                     nxt_state.digit_seen = 1'b0;
                  end else if (ch == CH_DASH && pe == PH_PATCH && ds) begin
                     nxt_state.phase = PH_SUF_EMPTY;
                  end else begin
                     nxt_state.failed = 1'b1;
                  end
               end
               PH_SUF_EMPTY, PH_SUF: begin
                  if (is_suffix_char(ch)) begin
                     nxt_state.phase = PH_SUF;
                  end else begin
                     nxt_state.failed = 1'b1;
                  end
               end
               default: begin
                  nxt_state.failed = 1'b1;
               end
            endcase
         end
      end
   end

endmodule

// ===== test/version_string_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// version_string_parser_tb: self-checking bench for the version string parser
// streams zero-terminated strings into the parser byte by byte, predicts the
// version record of each string and checks every result item field by field
// ----------------------------------------------------------------------------
module version_string_parser_tb;
   import vsp_pkg::*;

   localparam int ITEM_TARGET  = 1600;    // string bytes to queue in total
   localparam int DRAIN_CYCLES = 8;       // drain wait after the last record
   localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest passing run
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int HOLD_COUNT   = 2;
   localparam int HOLD_SPACING = 60;      // results between hold-offs

   typedef logic [7:0] char_type;

   // dut interface, every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   char_type    req_ch = CH_NUL;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_valid_res;
   logic [15:0] rsp_ver_major;
   logic [15:0] rsp_ver_minor;
   logic [15:0] rsp_ver_patch;
   logic        rsp_suffix_flag;

   // string bytes waiting for the driver
   char_type        pending_bytes[$];
   // version records predicted for terminators already accepted
   result_type      expected_versions[$];
   // predictor copy of the parser state
   parse_state_type parse_state = STATE_RESET;

   // driver bookkeeping
   logic req_fire = 1'b0;   // the byte on req_ch was taken at the last edge
   int   burst_left = 1;
   int   gap_left = 0;

   // receiver bookkeeping
   int   hold_left = 0;
   int   holds_done = 0;
   int   stall_mode = 0;
   int   pattern_cycles = 0;
   int   stall_phase = 0;
   logic stall_next;

   // run statistics
   int   error_count = 0;
   int   bytes_sent = 0;
   int   results_seen = 0;
   int   valid_count = 0;
   int   suffix_count = 0;
   int   saturated_count = 0;
   int   cycle_count = 0;

   version_string_parser u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_ver_major   (rsp_ver_major),
      .rsp_ver_minor   (rsp_ver_minor),
      .rsp_ver_patch   (rsp_ver_patch),
      .rsp_suffix_flag (rsp_suffix_flag)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor: one step of the version grammar per accepted byte
   // ---------------------------------------------------------------------
   function automatic bit is_dec(input char_type c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic bit is_tag_char(input char_type c);
      return is_dec(c) || (c >= CH_LO_A && c <= CH_LO_Z) ||
             (c >= CH_UP_A && c <= CH_UP_Z) || c == CH_DOT || c == CH_DASH;
   endfunction

   task automatic parse_byte(input char_type c);
      result_type  version;
      int unsigned next_val;
      bit          prefix;
      if (c == CH_NUL) begin
         // terminator: report the record, then start a fresh string
         version = '0;
         if (!parse_state.failed &&
             ((parse_state.phase == PH_PATCH && parse_state.digit_seen) ||
              parse_state.phase == PH_SUF)) begin
            version.valid_res   = 1'b1;
            version.ver_major   = parse_state.major_hold;
            version.ver_minor   = parse_state.minor_hold;
            version.ver_patch   = parse_state.accum;
            version.suffix_flag = (parse_state.phase == PH_SUF);
         end
         expected_versions.push_back(version);
         parse_state = STATE_RESET;
      end else if (!parse_state.failed) begin
         prefix = 1'b0;
         if (parse_state.phase == PH_START) begin
            parse_state.phase      = PH_MAJOR;
            parse_state.digit_seen = 1'b0;
            parse_state.accum      = '0;
            // a single leading v or V is swallowed
            prefix = (c == CH_LO_V || c == CH_UP_V);
         end
         if (!prefix) begin
            if (parse_state.phase >= PH_MAJOR && parse_state.phase <= PH_PATCH) begin
               if (is_dec(c)) begin
                  // base ten accumulate, clipped at the part limit
                  next_val = int'(parse_state.accum) * 10 + int'(c) - int'(CH_0);
                  parse_state.accum = (next_val > PART_LIMIT) ? PART_LIMIT
                                                               : next_val[15:0];
                  parse_state.digit_seen = 1'b1;
               end else if (c == CH_DOT && parse_state.phase < PH_PATCH &&
                            parse_state.digit_seen) begin
                  if (parse_state.phase == PH_MAJOR)
                     parse_state.major_hold = parse_state.accum;
                  else
                     parse_state.minor_hold = parse_state.accum;
                  parse_state.phase      = parse_state.phase + 3'd1;
                  parse_state.accum      = '0;
                  parse_state.digit_seen = 1'b0;
               end else if (c == CH_DASH && parse_state.phase == PH_PATCH &&
                            parse_state.digit_seen) begin
                  parse_state.phase = PH_SUF_EMPTY;
               end else begin
                  parse_state.failed = 1'b1;
               end
            end else if (parse_state.phase == PH_SUF_EMPTY ||
                         parse_state.phase == PH_SUF) begin
               // patch value stays in accum while the tag is read
               if (is_tag_char(c))
                  parse_state.phase = PH_SUF;
               else
                  parse_state.failed = 1'b1;
            end else begin
               parse_state.failed = 1'b1;
            end
         end
      end
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------
   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         pending_bytes.push_back(char_type'(s[i]));
   endtask

   // mostly well-formed versions with random content; some broken, some noise
   task automatic queue_random_string();
      char_type text[$];
      int       kind;
      int       n;
      int       pos;
      int       part;
      char_type tag;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         // raw noise, any nonzero byte including the high half
         n = $urandom_range(0, 10);
         repeat (n) text.push_back(char_type'($urandom_range(1, 255)));
      end else begin
         case ($urandom_range(0, 3))
            0: text.push_back(CH_LO_V);
            1: text.push_back(CH_UP_V);
            default: ;
         endcase
         for (part = 0; part < 3; part++) begin
            if (part > 0)
               text.push_back(CH_DOT);
            // long parts now and then to drive saturation
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                            : $urandom_range(1, 3);
            repeat (n) text.push_back(CH_0 + char_type'($urandom_range(0, 9)));
         end
         if ($urandom_range(0, 2) == 0) begin
            text.push_back(CH_DASH);
            n = $urandom_range(1, 6);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0: tag = CH_0 + char_type'($urandom_range(0, 9));
                  1: tag = CH_LO_A + char_type'($urandom_range(0, 25));
                  2: tag = CH_UP_A + char_type'($urandom_range(0, 25));
                  3: tag = CH_DOT;
                  default: tag = CH_DASH;
               endcase
               text.push_back(tag);
            end
         end
         if (kind >= 80) begin
            // break the sequence: corrupt, cut short or insert a byte
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
               0: text[pos] = char_type'($urandom_range(1, 255));
               1: while (text.size() > pos) void'(text.pop_back());
               default: text.insert(pos, char_type'($urandom_range(1, 255)));
            endcase
         end
      end
      foreach (text[i])
         pending_bytes.push_back(text[i]);
      pending_bytes.push_back(CH_NUL);
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of bytes with random gaps, changes on the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_ch    <= pending_bytes.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern of its own, plus long hold-offs that fill the
   // parser so that it has to stall its input
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      stall_next = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (!reset && holds_done < HOLD_COUNT &&
                   results_seen >= (holds_done + 1) * HOLD_SPACING) begin
         hold_left  = HOLD_CYCLES - 1;
         holds_done++;
         stall_next = 1'b1;
      end else begin
         if (pattern_cycles == 0) begin
            stall_mode     = $urandom_range(0, 3);
            pattern_cycles = $urandom_range(16, 96);
         end
         pattern_cycles--;
         stall_phase++;
         case (stall_mode)
            0: stall_next = 1'b0;                              // free running
            1: stall_next = ($urandom_range(0, 1) == 0);       // half the time
            2: stall_next = ($urandom_range(0, 4) != 0);       // mostly stalled
            default: stall_next = (stall_phase % 3 == 0);      // periodic
         endcase
      end
      rsp_stall <= stall_next;
   end

   // ---------------------------------------------------------------------
   // monitor: checks result items, then feeds accepted bytes to the predictor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         parse_state = STATE_RESET;
         expected_versions.delete();
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_versions.size() == 0) begin
               $error("result item with no terminated string outstanding");
               error_count++;
            end else begin
               automatic result_type want = expected_versions.pop_front();
               check_field("valid_res",   want.valid_res,   rsp_valid_res);
               check_field("ver_major",   want.ver_major,   rsp_ver_major);
               check_field("ver_minor",   want.ver_minor,   rsp_ver_minor);
               check_field("ver_patch",   want.ver_patch,   rsp_ver_patch);
               check_field("suffix_flag", want.suffix_flag, rsp_suffix_flag);
               results_seen++;
               if (want.valid_res)
                  valid_count++;
               if (want.suffix_flag)
                  suffix_count++;
               if (want.ver_major == PART_LIMIT || want.ver_minor == PART_LIMIT ||
                   want.ver_patch == PART_LIMIT)
                  saturated_count++;
            end
         end
         if (req_valid && !req_stall) begin
            bytes_sent++;
            parse_byte(req_ch);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("version_string_parser regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      // empty string
      pending_bytes.push_back(CH_NUL);
      // upper-case prefix, zero part, saturated patch and a tag
      queue_text("V0.9.99999-a");
      pending_bytes.push_back(CH_NUL);
      // lower-case prefix, string ends right after the dash
      queue_text("v1.2.3-");
      pending_bytes.push_back(CH_NUL);
      // high byte in the middle, then early end
      queue_text("1.2");
      pending_bytes.push_back(8'h80);
      pending_bytes.push_back(CH_NUL);
      // exact part limit in every field
      queue_text("65535.65535.65535");
      pending_bytes.push_back(CH_NUL);

      while (pending_bytes.size() < ITEM_TARGET)
         queue_random_string();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every byte to go in and every record to come back
      while (pending_bytes.size() != 0 || req_valid || expected_versions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_versions.size() != 0) begin
         $error("%0d version records never came out", expected_versions.size());
         error_count++;
      end
      $display("sent %0d bytes, checked %0d strings: %0d versions, %0d rejected",
               bytes_sent, results_seen, valid_count, results_seen - valid_count);
      $display("%0d versions carried a tag, %0d hit the part limit, %0d hold-offs",
               suffix_count, saturated_count, holds_done);
      if (error_count == 0)
         $display("version_string_parser regression: pass");
      else
         $display("version_string_parser regression: fail");
      $finish;
   end

endmodule

// ===== version_string_parser.f =====
rtl/vsp_pkg.sv
rtl/vsp_step.sv
rtl/version_string_parser.sv
test/version_string_parser_tb.sv
